### hw/rtl/frefb_pkg.sv
// ----------------------------------------------------------------------------
// frefb_pkg
// Shared types and constants for the frame reframe and escape bridge.
// ----------------------------------------------------------------------------
package frefb_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [15:0] MIN_LEN       = 16'd4;
  localparam logic [15:0] HDR_COUNT_MAX = 16'd4;

  localparam logic [7:0] HDR_A    = 8'hAA;
  localparam logic [7:0] HDR_B    = 8'h55;
  localparam logic [7:0] MARK_SOF = 8'h5A;
  localparam logic [7:0] MARK_EOF = 8'hA5;
  localparam logic [7:0] ESC      = 8'h80;
  localparam logic [7:0] ESC_SOF  = 8'h01;
  localparam logic [7:0] ESC_EOF  = 8'h02;
  localparam logic [7:0] ESC_ESC  = 8'h03;
  localparam logic [7:0] SOF_TYPE = 8'h03;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_IDLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    HS_NONE = 2'd0,
    HS_A    = 2'd1,
    HS_AB   = 2'd2
  } head_stage_e;

  // What the back end has to send for one item
  typedef enum logic [1:0] {
    CMD_HDR      = 2'd0,
    CMD_DATA     = 2'd1,
    CMD_DATA_EOF = 2'd2,
    CMD_EOF      = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [15:0] value;  // frame length for CMD_HDR, payload byte in [7:0] otherwise
  } cmd_t;

  typedef struct packed {
    logic       two;  // byte expands to an escape pair
    logic [7:0] b0;
    logic [7:0] b1;
  } esc_t;

endpackage

### hw/rtl/frefb_front.sv
// ----------------------------------------------------------------------------
// frefb_front
// Event front end: header hunt, length capture, counters and timeout.
// Pushes one send command per item that produces output.
// ----------------------------------------------------------------------------
module frefb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_kind_i,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                cmd_push_o,
  output frefb_pkg::cmd_t     cmd_o
);
  import frefb_pkg::*;

  logic [15:0] timeout_q;
  logic        fwd_q, fwd_d;
  head_stage_e hs_q, hs_d;
  logic [1:0]  ls_q, ls_d;
  logic [15:0] fl_q, fl_d;
  logic [15:0] bc_q, bc_d;
  logic [15:0] it_q, it_d;

  logic        accept;
  logic [15:0] it_tick;
  logic [15:0] bc_inc;
  logic [16:0] end_cnt;
  head_stage_e hs_n;
  logic [1:0]  ls_n;
  logic [15:0] fl_n;
  logic [15:0] bc_n;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign bc_inc      = bc_q + 16'd1;
  assign end_cnt     = {1'b0, fl_q} + 17'd2;

  always_comb begin
    fwd_d      = fwd_q;
    hs_d       = hs_q;
    ls_d       = ls_q;
    fl_d       = fl_q;
    bc_d       = bc_q;
    it_d       = it_q;
    hs_n       = hs_q;
    ls_n       = ls_q;
    fl_n       = fl_q;
    bc_n       = bc_q;
    it_tick    = (it_q != 16'hFFFF) ? it_q + 16'd1 : it_q;
    cmd_push_o = 1'b0;
    cmd_o.op    = CMD_EOF;
    cmd_o.value = {8'h00, in_byte_i};
    if (accept) begin
      case (kind_e'(in_kind_i))
        KIND_BYTE: begin
          if (!fwd_q) begin
            if (in_byte_i == HDR_A && hs_q == HS_NONE) begin
              hs_n = HS_A;
            end else if (in_byte_i == HDR_B && hs_q == HS_A) begin
              hs_n = HS_AB;
            end else if (hs_q == HS_AB && ls_q == 2'd0) begin
              fl_n = fl_q | {in_byte_i, 8'h00};
              ls_n = 2'd1;
            end else if (hs_q == HS_AB && ls_q == 2'd1) begin
              fl_n = fl_q | {8'h00, in_byte_i};
              ls_n = 2'd2;
            end else if (fl_q < MIN_LEN && ls_q == 2'd2) begin
              // short length: this byte only flushes the header
              hs_n = HS_NONE;
              ls_n = 2'd0;
              fl_n = '0;
              bc_n = '0;
            end
            // header bytes count, length bytes only up to four
            if ((hs_n == HS_A || hs_n == HS_AB) && ls_n == 2'd0) begin
              bc_n = bc_n + 16'd1;
            end else if ((ls_n == 2'd1 || ls_n == 2'd2) && bc_n < HDR_COUNT_MAX) begin
              bc_n = bc_n + 16'd1;
            end
            it_d = '0;
            if (hs_n == HS_AB && ls_n == 2'd2 && fl_n >= MIN_LEN) begin
              fwd_d       = 1'b1;
              hs_n        = HS_NONE;
              ls_n        = 2'd0;
              cmd_push_o  = 1'b1;
              cmd_o.op    = CMD_HDR;
              cmd_o.value = fl_n;
            end
            hs_d = hs_n;
            ls_d = ls_n;
            fl_d = fl_n;
            bc_d = bc_n;
          end else begin
            cmd_push_o = 1'b1;
            if (end_cnt == {1'b0, bc_inc}) begin
              cmd_o.op = CMD_DATA_EOF;
              fwd_d    = 1'b0;
              hs_d     = HS_NONE;
              ls_d     = 2'd0;
              fl_d     = '0;
              bc_d     = '0;
            end else begin
              cmd_o.op = CMD_DATA;
              bc_d     = bc_inc;
              it_d     = '0;
            end
          end
        end
        KIND_TICK, KIND_IDLE: begin
          if (kind_e'(in_kind_i) == KIND_TICK) begin
            it_d = it_tick;
          end
          if (!fwd_q) begin
            if (bc_q != '0 && it_d >= timeout_q) begin
              hs_d = HS_NONE;
              ls_d = 2'd0;
              fl_d = '0;
              bc_d = '0;
            end
          end else if (kind_e'(in_kind_i) == KIND_IDLE && end_cnt != {1'b0, bc_q}) begin
            cmd_push_o = 1'b1;
            cmd_o.op   = CMD_EOF;
            fwd_d      = 1'b0;
            hs_d       = HS_NONE;
            ls_d       = 2'd0;
            fl_d       = '0;
            bc_d       = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      fwd_q     <= 1'b0;
      hs_q      <= HS_NONE;
      ls_q      <= 2'd0;
      fl_q      <= '0;
      bc_q      <= '0;
      it_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
      fwd_q <= fwd_d;
      hs_q  <= hs_d;
      ls_q  <= ls_d;
      fl_q  <= fl_d;
      bc_q  <= bc_d;
      it_q  <= it_d;
    end
  end

  // header hunt state is parked while payload is forwarded
  a_fwd_hunt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (hs_q == HS_NONE && ls_q == 2'd0))
    else $error("header state active while forwarding");

  // length bytes are only taken after a full AA 55
  a_len_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ls_q != 2'd0) |-> (hs_q == HS_AB))
    else $error("length stage without header");

endmodule

### hw/rtl/frefb_queue.sv
// ----------------------------------------------------------------------------
// frefb_queue
// Small command FIFO between the event front end and the byte sender.
// ----------------------------------------------------------------------------
module frefb_queue #(
  parameter int unsigned Depth = frefb_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  frefb_pkg::cmd_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output frefb_pkg::cmd_t  data_o
);
  import frefb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("command queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty command queue");

endmodule

### hw/rtl/frefb_back.sv
// ----------------------------------------------------------------------------
// frefb_back
// Byte sender: expands one command into its escaped byte run and
// drives the registered output stream, one byte per transfer.
// ----------------------------------------------------------------------------
module frefb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  frefb_pkg::cmd_t  cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);
  import frefb_pkg::*;

  function automatic esc_t escape(input logic [7:0] v);
    esc_t e;
    e.two = 1'b1;
    e.b0  = ESC;
    e.b1  = ESC_ESC;
    case (v)
      MARK_SOF: e.b1 = ESC_SOF;
      MARK_EOF: e.b1 = ESC_EOF;
      ESC:      e.b1 = ESC_ESC;
      default: begin
        e.two = 1'b0;
        e.b0  = v;
        e.b1  = v;
      end
    endcase
    return e;
  endfunction

  logic [7:0] run [8];
  logic [3:0] cnt;
  logic [3:0] n;
  esc_t       e_hi;
  esc_t       e_lo;

  logic [2:0] ptr_q, ptr_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load;
  logic       is_last;

  // byte run for the command at the head of the queue
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      run[i] = '0;
    end
    e_hi = escape(cmd_i.value[15:8]);
    e_lo = escape(cmd_i.value[7:0]);
    n    = '0;
    case (cmd_i.op)
      CMD_HDR: begin
        run[0] = MARK_SOF;
        run[1] = SOF_TYPE;
        run[2] = HDR_A;
        run[3] = HDR_B;
        run[4] = e_hi.b0;
        run[5] = e_hi.b1;
        n      = e_hi.two ? 4'd6 : 4'd5;
        run[n[2:0]] = e_lo.b0;
        if (e_lo.two) begin
          run[n[2:0] + 3'd1] = e_lo.b1;
          n = n + 4'd2;
        end else begin
          n = n + 4'd1;
        end
      end
      CMD_DATA, CMD_DATA_EOF: begin
        run[0] = e_lo.b0;
        run[1] = e_lo.b1;
        n      = e_lo.two ? 4'd2 : 4'd1;
        if (cmd_i.op == CMD_DATA_EOF) begin
          run[n[2:0]] = MARK_EOF;
          n = n + 4'd1;
        end
      end
      CMD_EOF: begin
        run[0] = MARK_EOF;
        n      = 4'd1;
      end
      default: ;
    endcase
    cnt = n;
  end

  assign load      = cmd_valid_i && (!vld_q || out_ready_i);
  assign is_last   = (({1'b0, ptr_q} + 4'd1) == cnt);
  assign cmd_pop_o = load && is_last;

  always_comb begin
    ptr_d  = ptr_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    if (load) begin
      vld_d  = 1'b1;
      byte_d = run[ptr_q];
      last_d = is_last;
      ptr_d  = is_last ? 3'd0 : ptr_q + 3'd1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      vld_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  // run pointer never walks past the end of the head command
  a_ptr_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> ({1'b0, ptr_q} < cnt))
    else $error("run pointer beyond command length");

endmodule

### hw/rtl/frame_reframe_escape_bridge.sv
// ----------------------------------------------------------------------------
// frame_reframe_escape_bridge
// Reframes AA 55 <len16> frames as 5A 03 AA 55 <len> ... A5 with escaping.
// ----------------------------------------------------------------------------
// One event (received byte, timer tick or line idle) is taken per cycle
// while the command queue has room; ticks, idles and header bytes that send
// nothing never occupy it. Output bytes leave one per cycle from a
// registered stage while the sink is ready; a frame start sends 6 to 8 bytes,
// a payload byte 1 to 3 (with the closing A5) and an idle close 1. The
// sustained event rate is therefore set by the byte sender; the queue of
// QueueDepth commands absorbs bursts and lets either side stall alone.
// tlast marks the final byte sent for one event.
module frame_reframe_escape_bridge #(
  parameter int unsigned QueueDepth = frefb_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // timeout_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast
);
  import frefb_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  frefb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .q_full_i    (full),
    .cmd_push_o  (push),
    .cmd_o       (push_cmd)
  );

  frefb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  frefb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### tb/frame_reframe_escape_bridge_test.sv
// ----------------------------------------------------------------------------
// frame_reframe_escape_bridge_test
// Self-checking bench for the frame reframe and escape bridge.
// ----------------------------------------------------------------------------
// Events (bytes, ticks, line idles) go in on the slave stream from a queue.
// Each accepted transfer runs through a local model of the header hunt,
// escaping and frame close, which queues the bytes the bridge should send.
// The master stream is checked byte by byte, tlast included. Both sides
// stall in short random bursts. The timeout register is changed between
// phases, including a short tick run at the largest timeout.
module frame_reframe_escape_bridge_test;
  timeunit 1ns;
  timeprecision 1ps;

  import frefb_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
  } bridge_event_t;

  typedef struct {
    logic [7:0] value;
    logic       is_last;
  } bridge_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  frame_reframe_escape_bridge uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  bridge_event_t pending_events[$];
  bridge_byte_t  expected_bytes[$];
  int unsigned   events_queued = 0;
  int unsigned   events_taken = 0;
  int unsigned   error_count = 0;
  bit            gaps_on = 1'b0;
  int unsigned   src_gap = 0;
  int unsigned   sink_gap = 0;

  // Local copy of the bridge state
  logic        fwd_active = 1'b0;
  head_stage_e hdr_stage = HS_NONE;
  logic [1:0]  len_taken = '0;
  logic [15:0] frame_len = '0;
  logic [15:0] hdr_count = '0;
  logic [15:0] quiet_ticks = '0;
  logic [15:0] timeout_limit = TIMEOUT_RESET;

  function automatic void emit(input logic [7:0] b);
    expected_bytes.push_back('{value: b, is_last: 1'b0});
  endfunction

  function automatic void emit_escaped(input logic [7:0] b);
    if (b == MARK_SOF) begin
      emit(ESC);
      emit(ESC_SOF);
    end else if (b == MARK_EOF) begin
      emit(ESC);
      emit(ESC_EOF);
    end else if (b == ESC) begin
      emit(ESC);
      emit(ESC_ESC);
    end else begin
      emit(b);
    end
  endfunction

  function automatic void clear_header();
    hdr_count = '0;
    hdr_stage = HS_NONE;
    frame_len = '0;
    len_taken = '0;
  endfunction

  function automatic void close_frame();
    emit(MARK_EOF);
    fwd_active = 1'b0;
    clear_header();
  endfunction

  // Advance the local state by one accepted event and queue what it sends
  function automatic void reframe_event(input kind_e kind, input logic [7:0] b);
    int           before_n;
    bridge_byte_t tail;
    before_n = expected_bytes.size();
    case (kind)
      KIND_BYTE: begin
        if (!fwd_active) begin
          if (b == HDR_A && hdr_stage == HS_NONE) begin
            hdr_stage = HS_A;
          end else if (b == HDR_B && hdr_stage == HS_A) begin
            hdr_stage = HS_AB;
          end else if (hdr_stage == HS_AB && len_taken == 2'd0) begin
            frame_len = frame_len | {b, 8'h00};
            len_taken = 2'd1;
          end else if (hdr_stage == HS_AB && len_taken == 2'd1) begin
            frame_len = frame_len | {8'h00, b};
            len_taken = 2'd2;
          end else if (frame_len < MIN_LEN && len_taken == 2'd2) begin
            // short length: this byte only clears, it is not looked at
            clear_header();
          end
          // stray bytes inside the header still count
          if (hdr_stage != HS_NONE && len_taken == 2'd0) hdr_count++;
          if (len_taken != 2'd0 && hdr_count < HDR_COUNT_MAX) hdr_count++;
          quiet_ticks = '0;
          if (hdr_stage == HS_AB && len_taken == 2'd2 && frame_len >= MIN_LEN) begin
            fwd_active = 1'b1;
            emit(MARK_SOF);
            emit(SOF_TYPE);
            emit(HDR_A);
            emit(HDR_B);
            emit_escaped(frame_len[15:8]);
            emit_escaped(frame_len[7:0]);
            len_taken = '0;
            hdr_stage = HS_NONE;
          end
        end else begin
          hdr_count++;
          emit_escaped(b);
          // 17-bit compare, the count may never match
          if ({1'b0, frame_len} + 17'd2 == {1'b0, hdr_count}) close_frame();
          else quiet_ticks = '0;
        end
      end
      KIND_TICK, KIND_IDLE: begin
        if (kind == KIND_TICK && quiet_ticks != 16'hFFFF) quiet_ticks++;
        if (!fwd_active) begin
          if (hdr_count != '0 && quiet_ticks >= timeout_limit) clear_header();
        end else if (kind == KIND_IDLE &&
                     {1'b0, frame_len} + 17'd2 != {1'b0, hdr_count}) begin
          close_frame();
        end
      end
      default: ;
    endcase
    if (expected_bytes.size() > before_n) begin
      tail = expected_bytes.pop_back();
      tail.is_last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  // Event source
  always @(posedge clk_i or negedge rst_ni) begin : source_drive
    bridge_event_t ev;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        src_gap <= $urandom_range(0, 2);
        s_axis_tvalid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        ev = pending_events.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ev.data;
        s_axis_tuser <= ev.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Byte sink back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      sink_gap <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin : monitor
    bridge_byte_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        reframe_event(kind_e'(s_axis_tuser), s_axis_tdata);
        events_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h (tlast %0b), nothing expected",
                   $time, m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.value) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.value, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tlast !== want.is_last) begin
            $display("%0t: tlast mismatch, expected %0b, actual %0b",
                     $time, want.is_last, m_axis_tlast);
            error_count++;
          end
        end
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return MARK_SOF;
      1: return MARK_EOF;
      2: return ESC;
      3: return HDR_A;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_event(input kind_e kind, input logic [7:0] b);
    pending_events.push_back('{kind: kind, data: b});
    events_queued++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_event(KIND_BYTE, b);
  endtask

  task automatic add_tick();
    add_event(KIND_TICK, 8'($urandom));
  endtask

  task automatic add_idle();
    add_event(KIND_IDLE, 8'($urandom));
  endtask

  task automatic add_frame(input logic [15:0] len, input int n_payload, input bit idle_close);
    add_byte(HDR_A);
    add_byte(HDR_B);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    repeat (n_payload) begin
      if ($urandom_range(0, 7) == 0) add_tick();
      add_byte(pick_byte());
    end
    if (idle_close) add_idle();
  endtask

  // Mostly well-formed frames, the rest broken headers and noise
  task automatic add_random_traffic(input int n_items);
    int unsigned stop_at;
    logic [15:0] len;
    int          n;
    stop_at = events_queued + n_items;
    while (events_queued < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 5) == 0) begin
            // usually a long length, so the closing idle ends it
            len = {pick_byte(), pick_byte()};
            add_frame(len, $urandom_range(0, 3), 1'b1);
          end else begin
            len = 16'($urandom_range(4, 10));
            n = int'(len) - 2;
            if ($urandom_range(0, 7) == 0) add_frame(len, $urandom_range(0, n - 1), 1'b1);
            else add_frame(len, n, 1'b0);
          end
        end
        6: begin
          add_byte(HDR_A);
          add_byte(HDR_B);
          add_byte(8'h00);
          add_byte(8'($urandom_range(0, 3)));
          add_byte(pick_byte());
        end
        7: begin
          add_byte(HDR_A);
          repeat ($urandom_range(1, 3)) add_byte(pick_byte());
          add_frame(16'($urandom_range(4, 8)), $urandom_range(0, 6), 1'b1);
        end
        8: begin
          add_byte(HDR_A);
          if ($urandom_range(0, 1) == 1) add_byte(HDR_B);
          repeat ($urandom_range(1, 4)) add_tick();
        end
        default: add_event(kind_e'($urandom_range(0, 2)), 8'($urandom));
      endcase
    end
  endtask

  // Block until every event is taken and every byte seen, then let it settle
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || events_taken != events_queued ||
           expected_bytes.size() != 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout_limit = value;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    gaps_on = 1'b1;

    // nothing to time out, nothing to close
    add_tick();
    add_idle();
    // shortest frame, escaped payload, closed by count
    add_byte(HDR_A);
    add_byte(HDR_B);
    add_byte(8'h00);
    add_byte(8'h04);
    add_byte(MARK_SOF);
    add_byte(MARK_EOF);
    // both length bytes escaped, closed by line idle
    add_byte(HDR_A);
    add_byte(HDR_B);
    add_byte(MARK_SOF);
    add_byte(MARK_EOF);
    add_byte(ESC);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_idle();
    // stray byte inside the header, then a short length dropped by next byte
    add_byte(HDR_A);
    add_byte(8'h33);
    add_byte(HDR_B);
    add_byte(8'h00);
    add_byte(8'h03);
    add_byte(8'h77);
    add_random_traffic(20);
    wait_quiet();

    // smallest timeout: a single tick drops a partial header, an idle does not
    write_timeout(16'd1);
    add_byte(HDR_A);
    add_tick();
    add_byte(HDR_B);
    add_byte(8'h00);
    add_byte(8'h04);
    add_byte(HDR_A);
    add_byte(HDR_B);
    add_idle();
    add_tick();
    add_byte(8'h00);
    add_byte(8'h04);
    add_random_traffic(20);
    wait_quiet();

    // largest timeout: a few ticks leave the partial header in place
    write_timeout(16'hFFFF);
    add_byte(HDR_A);
    add_byte(HDR_B);
    add_byte(8'h12);
    repeat (3) add_tick();
    add_byte(8'h00);
    add_byte(8'h04);
    add_random_traffic(15);
    wait_quiet();

    // closing phase without stalls
    write_timeout(16'($urandom_range(2, 8)));
    gaps_on = 1'b0;
    add_random_traffic(25);
    wait_quiet();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### frame_reframe_escape_bridge.f
hw/rtl/frefb_pkg.sv
hw/rtl/frefb_front.sv
hw/rtl/frefb_queue.sv
hw/rtl/frefb_back.sv
hw/rtl/frame_reframe_escape_bridge.sv
tb/frame_reframe_escape_bridge_test.sv
